[hw/rtl/rgbab_pkg.sv]
// rgbab_pkg: shared types, constants and channel helpers for the rgb565 blender
// used by rgbab_blend_core and rgb565_alpha_add_blender; no dependencies
`default_nettype none

package rgbab_pkg;

	// blend mode register codes, code 3 behaves as opaque
	typedef enum logic [1:0] {
		MODE_OPAQUE = 2'd0,
		MODE_OVER   = 2'd1,
		MODE_ADD    = 2'd2
	} blend_mode_t;

	localparam int unsigned PIXEL_W = 16;
	localparam int unsigned ALPHA_W = 8;
	localparam int unsigned CHAN_W  = 8;
	localparam int unsigned IN_DATA_W  = 2 * PIXEL_W + ALPHA_W;
	localparam int unsigned OUT_DATA_W = PIXEL_W;

	localparam logic [CHAN_W-1:0]  CHAN_MAX  = 8'd255;
	localparam logic [15:0]        ROUND_OFS = 16'd127;

	// widen a 5-bit channel to 8 bits by bit replication
	function automatic logic [CHAN_W-1:0] widen5(input logic [4:0] v);
		return {v, v[4:2]};
	endfunction

	// widen a 6-bit channel to 8 bits by bit replication
	function automatic logic [CHAN_W-1:0] widen6(input logic [5:0] v);
		return {v, v[5:4]};
	endfunction

	// floor(y / 255) for y up to 65152, by shift and add
	function automatic logic [CHAN_W-1:0] div255(input logic [15:0] y);
		logic [16:0] t;
		t = {1'b0, y} + 17'd1 + {9'd0, y[15:8]};
		return t[15:8];
	endfunction

endpackage

`default_nettype wire

[hw/rtl/rgbab_blend_core.sv]
// rgbab_blend_core: single-pass combinational blend of one source and one
// destination rgb565 pixel; depends on rgbab_pkg
`default_nettype none

module rgbab_blend_core
	import rgbab_pkg::*;
(
	input  wire blend_mode_t           mode,
	input  wire logic [PIXEL_W-1:0]    src_pixel,
	input  wire logic [ALPHA_W-1:0]    alpha,
	input  wire logic [PIXEL_W-1:0]    dst_pixel,
	output logic      [PIXEL_W-1:0]    out_pixel
);

	logic [CHAN_W-1:0] s_ch [3];
	logic [CHAN_W-1:0] d_ch [3];
	logic [CHAN_W-1:0] over_ch [3];
	logic [CHAN_W-1:0] add_ch [3];
	logic [ALPHA_W-1:0] inv_alpha;

	// unpack both pixels to 8-bit channels, index 0 red, 1 green, 2 blue
	always_comb begin
		s_ch[0] = widen5(src_pixel[15:11]);
		s_ch[1] = widen6(src_pixel[10:5]);
		s_ch[2] = widen5(src_pixel[4:0]);
		d_ch[0] = widen5(dst_pixel[15:11]);
		d_ch[1] = widen6(dst_pixel[10:5]);
		d_ch[2] = widen5(dst_pixel[4:0]);
	end

	assign inv_alpha = CHAN_MAX - alpha;

	// per-channel over and additive mixes
	always_comb begin
		logic [15:0] prod_s;
		logic [15:0] prod_d;
		logic [8:0]  add_sum;
		for (int i = 0; i < 3; i++) begin
			prod_s = s_ch[i] * alpha;
			prod_d = d_ch[i] * inv_alpha;
			over_ch[i] = div255(prod_s + prod_d + ROUND_OFS);
			add_sum = {1'b0, div255(prod_s + ROUND_OFS)} + {1'b0, d_ch[i]};
			add_ch[i] = add_sum[8] ? CHAN_MAX : add_sum[7:0];
		end
	end

	// repack by dropping low bits, opaque passes the source through
	always_comb begin
		case (mode)
			MODE_OVER: out_pixel = {over_ch[0][7:3], over_ch[1][7:2], over_ch[2][7:3]};
			MODE_ADD:  out_pixel = {add_ch[0][7:3], add_ch[1][7:2], add_ch[2][7:3]};
			default:   out_pixel = src_pixel;
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/rgb565_alpha_add_blender.sv]
// rgb565_alpha_add_blender: top level, input register, blend core, result register
// depends on rgbab_pkg and rgbab_blend_core
//
//   channel   dir  handshake                    content
//   s_axis    in   s_axis_tvalid/s_axis_tready  src_pixel, alpha, dst_pixel
//   m_axis    out  m_axis_tvalid/m_axis_tready  out_pixel
//   cfg       in   cfg_wr_en (no wait)          blend_mode
//
// one pixel per clock sustained while m_axis_tready holds; two register stages, so a
// result is shown on m_axis after its input transaction has passed both (input
// register, then the result register after the 8x8 multiplies and divide-by-255 of the blend core)
// arst_n clears both stage valid flags and sets blend_mode to opaque
// a stalled output holds its result; the input register still fills behind it
`default_nettype none

module rgb565_alpha_add_blender
	import rgbab_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration
	input  wire logic                  cfg_wr_en,
	input  wire logic [1:0]            cfg_wr_data,
	// input stream
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // src_pixel[15:0], alpha[23:16], dst_pixel[39:24]
	// output stream
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0]      m_axis_tdata   // out_pixel[15:0]
);

	blend_mode_t          blend_mode_q;
	logic                 valid_s1;
	logic [PIXEL_W-1:0]   src_pixel_s1;
	logic [ALPHA_W-1:0]   alpha_s1;
	logic [PIXEL_W-1:0]   dst_pixel_s1;
	logic                 valid_s2;
	logic [PIXEL_W-1:0]   out_pixel_s2;
	logic [PIXEL_W-1:0]   mixed_pixel;
	logic                 adv_s2;
	logic                 adv_s1;

	// stage advance
	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign adv_s1        = !valid_s1 || adv_s2;
	assign s_axis_tready = adv_s1;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_mode_q <= MODE_OPAQUE;
		end else if (cfg_wr_en) begin
			blend_mode_q <= blend_mode_t'(cfg_wr_data);
		end
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (adv_s1 && s_axis_tvalid) begin
			src_pixel_s1 <= s_axis_tdata[15:0];
			alpha_s1     <= s_axis_tdata[23:16];
			dst_pixel_s1 <= s_axis_tdata[39:24];
		end
	end

	rgbab_blend_core u_core (
		.mode      (blend_mode_q),
		.src_pixel (src_pixel_s1),
		.alpha     (alpha_s1),
		.dst_pixel (dst_pixel_s1),
		.out_pixel (mixed_pixel)
	);

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			out_pixel_s2 <= mixed_pixel;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = out_pixel_s2;

endmodule

`default_nettype wire

[hw/rtl/rgbab_checker.sv]
// rgbab_checker: port-level assertions for rgb565_alpha_add_blender, with bind
// depends on rgbab_pkg and the top level port list
`default_nettype none

module rgbab_checker
	import rgbab_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_axis_tvalid,
	input wire logic                  s_axis_tready,
	input wire logic                  m_axis_tvalid,
	input wire logic                  m_axis_tready,
	input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

	// a stalled result holds valid and data
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// an empty output never blocks the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input blocked with output empty");

	// a draining output keeps the input open for back to back transactions
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input blocked while output drains");

	// a new result follows an input transaction, through the input and result registers
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result without input transaction");

endmodule

bind rgb565_alpha_add_blender rgbab_checker u_rgbab_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
